// ----- hdl/priority_schedule_engine_unit_defines.svh -----
// assertion macros shared by the checker files of the priority schedule engine
// no dependencies; taken in by `include with the bare file name
`ifndef PRIORITY_SCHEDULE_ENGINE_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULE_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define PSE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define PSE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pse_pkg.sv -----
// shared types and constants of the priority schedule engine
// no dependencies; imported by every module of the block
package pse_pkg;

    localparam int MAX_PROCS_DEF = 16;
    localparam int ID_W          = 8;
    localparam int ARR_W         = 16;
    localparam int BURST_W       = 16;
    localparam int PRIO_W        = 8;
    localparam int TIME_W        = 21;
    localparam int SUM_W         = 25;

    typedef struct packed {
        logic [ID_W-1:0]    process_id;
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  priority_value;
        logic               last_process;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [TIME_W-1:0] completion_time;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic [SUM_W-1:0]  total_turnaround;
        logic [SUM_W-1:0]  total_waiting;
        logic              last_result;
    } result_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic mark;
        logic shift;
    } cell_ctl_t;

    // running best candidate and earliest pending arrival, passed along the row
    typedef struct packed {
        logic               found;
        logic [PRIO_W-1:0]  prio;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic               pend;
        logic [ARR_W-1:0]   next_arr;
    } token_t;

endpackage

// ----- hdl/pse_cell.sv -----
// one slot of the process table: holds a record, joins the selection token
// that runs along the row, and shifts its results towards slot zero
// depends on pse_pkg
module pse_cell
    import pse_pkg::*;
#(
    parameter int SLOT_W = $clog2(MAX_PROCS_DEF),
    parameter int CLK_W  = ARR_W + $clog2(MAX_PROCS_DEF + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] my_slot,
    input  logic              live,
    input  cell_ctl_t         ctl,
    input  logic [SLOT_W-1:0] sel_slot,
    input  item_t             rec,
    input  logic [CLK_W-1:0]  clk_now,
    input  logic [CLK_W-1:0]  fin_clk,
    input  token_t            tok_in,
    input  logic [SLOT_W-1:0] tok_slot_in,
    output token_t            tok_out,
    output logic [SLOT_W-1:0] tok_slot_out,
    input  logic [ID_W-1:0]   sh_id_in,
    input  logic [CLK_W-1:0]  sh_fin_in,
    input  logic [CLK_W-1:0]  sh_tat_in,
    input  logic [CLK_W-1:0]  sh_wt_in,
    output logic [ID_W-1:0]   sh_id_out,
    output logic [CLK_W-1:0]  sh_fin_out,
    output logic [CLK_W-1:0]  sh_tat_out,
    output logic [CLK_W-1:0]  sh_wt_out
);

    logic [ID_W-1:0]    id_reg;
    logic [ARR_W-1:0]   arr_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [CLK_W-1:0]   fin_reg;
    logic [CLK_W-1:0]   tat_reg;
    logic [CLK_W-1:0]   wt_reg;
    logic               done_reg;
    logic               done_next;
    token_t             tok_reg;
    token_t             tok_next;
    logic [SLOT_W-1:0]  tok_slot_reg;
    logic [SLOT_W-1:0]  tok_slot_next;

    logic               sel_hit;
    logic [CLK_W-1:0]   arr_ext;
    logic               open_q;
    logic               arrived;

    assign sel_hit = (sel_slot == my_slot);
    assign arr_ext = CLK_W'(arr_reg);
    assign open_q  = live && !done_reg;
    assign arrived = (arr_ext <= clk_now);

    always_comb
    begin
        tok_next      = tok_in;
        tok_slot_next = tok_slot_in;
        // strictly better only, so a tie stays with the lower slot upstream
        if (open_q && arrived &&
            (!tok_in.found || (prio_reg < tok_in.prio) ||
             ((prio_reg == tok_in.prio) && (arr_reg < tok_in.arr))))
        begin
            tok_next.found = 1'b1;
            tok_next.prio  = prio_reg;
            tok_next.arr   = arr_reg;
            tok_next.burst = burst_reg;
            tok_slot_next  = my_slot;
        end
        if (open_q && !arrived && (!tok_in.pend || (arr_reg < tok_in.next_arr)))
        begin
            tok_next.pend     = 1'b1;
            tok_next.next_arr = arr_reg;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (ctl.shift)
        begin
            done_next = 1'b0;
        end
        else if (ctl.mark && sel_hit)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            tok_reg      <= '0;
            tok_slot_reg <= '0;
        end
        else
        begin
            done_reg     <= done_next;
            tok_reg      <= tok_next;
            tok_slot_reg <= tok_slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load && sel_hit)
        begin
            id_reg    <= rec.process_id;
            arr_reg   <= rec.arrival_time;
            burst_reg <= rec.burst_time;
            prio_reg  <= rec.priority_value;
        end
        else if (ctl.mark && sel_hit)
        begin
            fin_reg <= fin_clk;
            tat_reg <= fin_clk - arr_ext;
            // start time minus arrival equals turnaround minus burst
            wt_reg  <= clk_now - arr_ext;
        end
        else if (ctl.shift)
        begin
            id_reg  <= sh_id_in;
            fin_reg <= sh_fin_in;
            tat_reg <= sh_tat_in;
            wt_reg  <= sh_wt_in;
        end
    end

    assign tok_out      = tok_reg;
    assign tok_slot_out = tok_slot_reg;
    assign sh_id_out    = id_reg;
    assign sh_fin_out   = fin_reg;
    assign sh_tat_out   = tat_reg;
    assign sh_wt_out    = wt_reg;

endmodule

// ----- hdl/priority_schedule_engine_unit.sv -----
// Non-preemptive priority scheduler over a batch of up to MAX_PROCS process records.
// Records are taken one per cycle while item_stall is low; records beyond MAX_PROCS
// are dropped, and the record marked last closes the batch and raises item_stall.
// For each scheduling decision a candidate token crosses the row of MAX_PROCS cells
// one cell per cycle, then the sequencer acts on the token at the tail of the row.
// A batch of L records needs at most 2 * L decisions (one run per process plus
// idle jumps of the schedule clock), then L results leave one per cycle when the
// output is not stalled, in load order with running totals. Averages are left
// to software. item_stall drops again once the last result is in the output register.
// depends on pse_pkg and pse_cell
module priority_schedule_engine_unit
    import pse_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int SLOT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CLK_W  = ARR_W + $clog2(MAX_PROCS + 1);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CLK_W-1:0]  clock_reg, clock_next;
    logic [CNT_W-1:0]  wait_reg, wait_next;
    logic [CNT_W-1:0]  done_cnt_reg, done_cnt_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic [SUM_W-1:0]  sum_tat_reg, sum_tat_next;
    logic [SUM_W-1:0]  sum_wt_reg, sum_wt_next;

    token_t            tok_w     [MAX_PROCS+1];
    logic [SLOT_W-1:0] tslot_w   [MAX_PROCS+1];
    logic [ID_W-1:0]   sh_id_w   [MAX_PROCS+1];
    logic [CLK_W-1:0]  sh_fin_w  [MAX_PROCS+1];
    logic [CLK_W-1:0]  sh_tat_w  [MAX_PROCS+1];
    logic [CLK_W-1:0]  sh_wt_w   [MAX_PROCS+1];

    cell_ctl_t         ctl;
    logic [SLOT_W-1:0] sel_slot;
    logic [CLK_W-1:0]  fin_clk;
    token_t            tail;
    logic              item_take;
    logic              act;
    logic              emit_go;
    logic              last_emit;
    logic              last_done;

    assign tok_w[0]           = '0;
    assign tslot_w[0]         = '0;
    assign sh_id_w[MAX_PROCS]  = '0;
    assign sh_fin_w[MAX_PROCS] = '0;
    assign sh_tat_w[MAX_PROCS] = '0;
    assign sh_wt_w[MAX_PROCS]  = '0;

    for (genvar g = 0; g < MAX_PROCS; g++)
    begin : g_cell
        pse_cell #(
            .SLOT_W (SLOT_W),
            .CLK_W  (CLK_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .my_slot      (SLOT_W'(g)),
            .live         (CNT_W'(g) < count_reg),
            .ctl          (ctl),
            .sel_slot     (sel_slot),
            .rec          (item),
            .clk_now      (clock_reg),
            .fin_clk      (fin_clk),
            .tok_in       (tok_w[g]),
            .tok_slot_in  (tslot_w[g]),
            .tok_out      (tok_w[g+1]),
            .tok_slot_out (tslot_w[g+1]),
            .sh_id_in     (sh_id_w[g+1]),
            .sh_fin_in    (sh_fin_w[g+1]),
            .sh_tat_in    (sh_tat_w[g+1]),
            .sh_wt_in     (sh_wt_w[g+1]),
            .sh_id_out    (sh_id_w[g]),
            .sh_fin_out   (sh_fin_w[g]),
            .sh_tat_out   (sh_tat_w[g]),
            .sh_wt_out    (sh_wt_w[g])
        );
    end

    assign tail       = tok_w[MAX_PROCS];
    assign fin_clk    = clock_reg + CLK_W'(tail.burst);
    assign item_stall = (state_reg != S_LOAD);
    assign item_take  = item_valid && !item_stall;
    // the sequencer acts only once the token has seen every cell under the current state
    assign act        = (state_reg == S_SCAN) && (wait_reg == CNT_W'(MAX_PROCS));
    assign emit_go    = (state_reg == S_EMIT) && (!out_valid_reg || !result_stall);
    assign last_emit  = (emit_cnt_reg == (count_reg - 1'b1));
    assign last_done  = ((done_cnt_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        clock_next     = clock_reg;
        wait_next      = wait_reg;
        done_cnt_next  = done_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        sum_tat_next   = sum_tat_reg;
        sum_wt_next    = sum_wt_reg;
        ctl            = '0;
        sel_slot       = SLOT_W'(count_reg);

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (item_take)
                begin
                    // a full table drops the record but still honours its last mark
                    if (count_reg < CNT_W'(MAX_PROCS))
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (item.last_process)
                    begin
                        state_next    = S_SCAN;
                        wait_next     = '0;
                        done_cnt_next = '0;
                    end
                end
            end
            S_SCAN:
            begin
                if (act)
                begin
                    wait_next = '0;
                    if (tail.found)
                    begin
                        ctl.mark      = 1'b1;
                        sel_slot      = tslot_w[MAX_PROCS];
                        clock_next    = fin_clk;
                        done_cnt_next = done_cnt_reg + 1'b1;
                        if (last_done)
                        begin
                            state_next    = S_EMIT;
                            emit_cnt_next = '0;
                            sum_tat_next  = '0;
                            sum_wt_next   = '0;
                        end
                    end
                    else
                    begin
                        // nothing has arrived: jump to the earliest pending arrival
                        clock_next = CLK_W'(tail.next_arr);
                    end
                end
                else
                begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    ctl.shift                 = 1'b1;
                    out_valid_next            = 1'b1;
                    sum_tat_next              = sum_tat_reg + SUM_W'(sh_tat_w[0]);
                    sum_wt_next               = sum_wt_reg + SUM_W'(sh_wt_w[0]);
                    out_next.result_id        = sh_id_w[0];
                    out_next.completion_time  = TIME_W'(sh_fin_w[0]);
                    out_next.turnaround_time  = TIME_W'(sh_tat_w[0]);
                    out_next.waiting_time     = TIME_W'(sh_wt_w[0]);
                    out_next.total_turnaround = sum_tat_next;
                    out_next.total_waiting    = sum_wt_next;
                    out_next.last_result      = last_emit;
                    emit_cnt_next             = emit_cnt_reg + 1'b1;
                    if (last_emit)
                    begin
                        state_next = S_LOAD;
                        count_next = '0;
                        clock_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            clock_reg     <= '0;
            wait_reg      <= '0;
            done_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clock_reg     <= clock_next;
            wait_reg      <= wait_next;
            done_cnt_reg  <= done_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        sum_tat_reg <= sum_tat_next;
        sum_wt_reg  <= sum_wt_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- hdl/pse_checker.sv -----
// port-level checks of the priority schedule engine, bound to its top level
// depends on pse_pkg and priority_schedule_engine_unit_defines.svh
`include "priority_schedule_engine_unit_defines.svh"

module pse_checker
    import pse_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input item_t   item,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // a stalled result holds until its transfer
    `PSE_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // loading goes on after a record that does not close the batch
    `PSE_ASSERT_NEXT(a_load_open, clk, rst_n, item_valid && !item_stall && !item.last_process, !item_stall, "loading stopped before the last record")

    // the closing record starts scheduling
    `PSE_ASSERT_NEXT(a_close_stall, clk, rst_n, item_valid && !item_stall && item.last_process, item_stall, "input open after the closing record")

    // no new batch while results of the current one are still to come
    `PSE_ASSERT_IMP(a_emit_stall, clk, rst_n, result_valid && !result.last_result, item_stall, "input open before the last result")

endmodule

bind priority_schedule_engine_unit pse_checker u_pse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- test/priority_schedule_engine_unit_checker.sv -----
`timescale 1ns / 1ps
// checker of the priority schedule engine: follows both channels, predicts the
// per-process reports of each batch and compares them in order; depends on pse_pkg
module priority_schedule_engine_unit_checker
    import pse_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned reports_seen,
    output int unsigned batches_seen
);

    item_t       table_rows [MAX_PROCS];
    int unsigned rows_loaded;
    result_t     process_reports [$];
    int unsigned mismatches;
    int unsigned checked_reports;
    int unsigned closed_batches;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t report %0d, %s: got %0d, expected %0d",
                 $time, checked_reports, field, got, want);
        mismatches++;
    endtask

    // non-preemptive schedule of the loaded table, then one report per slot
    function automatic void plan_batch();
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] finish [MAX_PROCS];
        bit                done [MAX_PROCS];
        int unsigned       left;
        int unsigned       best;
        bit                found;
        bit                pend;
        logic [ARR_W-1:0]  next_arr;
        logic [TIME_W-1:0] tat;
        logic [TIME_W-1:0] wt;
        logic [SUM_W-1:0]  sum_tat;
        logic [SUM_W-1:0]  sum_wt;
        result_t           rep;
        now = '0;
        left = rows_loaded;
        sum_tat = '0;
        sum_wt = '0;
        for (int s = 0; s < MAX_PROCS; s++)
        begin
            done[s] = 1'b0;
            finish[s] = '0;
        end
        while (left != 0)
        begin
            found = 1'b0;
            pend = 1'b0;
            best = 0;
            next_arr = '0;
            for (int s = 0; s < rows_loaded; s++)
            begin
                if (done[s])
                    continue;
                if (TIME_W'(table_rows[s].arrival_time) <= now)
                begin
                    // strict compares keep the lower slot on a full tie
                    if (!found
                        || table_rows[s].priority_value < table_rows[best].priority_value
                        || (table_rows[s].priority_value == table_rows[best].priority_value
                            && table_rows[s].arrival_time < table_rows[best].arrival_time))
                    begin
                        found = 1'b1;
                        best = s;
                    end
                end
                else if (!pend || table_rows[s].arrival_time < next_arr)
                begin
                    pend = 1'b1;
                    next_arr = table_rows[s].arrival_time;
                end
            end
            if (found)
            begin
                now = now + TIME_W'(table_rows[best].burst_time);
                finish[best] = now;
                done[best] = 1'b1;
                left--;
            end
            else
                now = TIME_W'(next_arr);   // nothing ready: jump to next arrival
        end
        for (int s = 0; s < rows_loaded; s++)
        begin
            tat = finish[s] - TIME_W'(table_rows[s].arrival_time);
            wt = tat - TIME_W'(table_rows[s].burst_time);
            sum_tat = sum_tat + SUM_W'(tat);
            sum_wt = sum_wt + SUM_W'(wt);
            rep.result_id = table_rows[s].process_id;
            rep.completion_time = finish[s];
            rep.turnaround_time = tat;
            rep.waiting_time = wt;
            rep.total_turnaround = sum_tat;
            rep.total_waiting = sum_wt;
            rep.last_result = (s == rows_loaded - 1);
            process_reports.push_back(rep);
        end
        rows_loaded = 0;
    endfunction

    function automatic void take_record(input item_t rec);
        // a full table drops the record, but a last flag still closes the batch
        if (rows_loaded < MAX_PROCS)
        begin
            table_rows[rows_loaded] = rec;
            rows_loaded++;
        end
        if (rec.last_process)
        begin
            closed_batches++;
            plan_batch();
        end
    endfunction

    task automatic check_report(input result_t got);
        result_t want;
        checked_reports++;
        if (process_reports.size() == 0)
        begin
            report_mismatch("unexpected report, result_id", got.result_id, '0);
            return;
        end
        want = process_reports.pop_front();
        if (got.result_id !== want.result_id)
            report_mismatch("result_id", got.result_id, want.result_id);
        if (got.completion_time !== want.completion_time)
            report_mismatch("completion_time", got.completion_time, want.completion_time);
        if (got.turnaround_time !== want.turnaround_time)
            report_mismatch("turnaround_time", got.turnaround_time, want.turnaround_time);
        if (got.waiting_time !== want.waiting_time)
            report_mismatch("waiting_time", got.waiting_time, want.waiting_time);
        if (got.total_turnaround !== want.total_turnaround)
            report_mismatch("total_turnaround", got.total_turnaround, want.total_turnaround);
        if (got.total_waiting !== want.total_waiting)
            report_mismatch("total_waiting", got.total_waiting, want.total_waiting);
        if (got.last_result !== want.last_result)
            report_mismatch("last_result", got.last_result, want.last_result);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_report(result);
            if (item_valid && !item_stall)
                take_record(item);
        end
        pending <= process_reports.size();
        fail_count <= mismatches;
        reports_seen <= checked_reports;
        batches_seen <= closed_batches;
    end

endmodule

// ----- test/priority_schedule_engine_unit_tb.sv -----
`timescale 1ns / 1ps
// testbench top of the priority schedule engine: clock, reset, record stimulus,
// result back-pressure and the verdict; depends on pse_pkg, the block and its checker
module priority_schedule_engine_unit_tb;
    import pse_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_RECORDS = 105;
    localparam int LONG_HOLD      = 1000;
    localparam int TAIL_CYCLES    = (MAX_PROCS_DEF + 1) * 2 * MAX_PROCS_DEF
                                    + 4 * MAX_PROCS_DEF;
    localparam int IDLE_LIMIT     = 6000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    int unsigned fail_count;
    int unsigned pending_reports;
    int unsigned reports_seen;
    int unsigned batches_seen;
    int unsigned hold_requests = 0;
    int unsigned idle_cycles = 0;
    int unsigned records_sent = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    priority_schedule_engine_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    priority_schedule_engine_unit_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending_reports),
        .reports_seen (reports_seen),
        .batches_seen (batches_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic item_t make_record(input logic [ID_W-1:0] id,
                                          input logic [ARR_W-1:0] arr,
                                          input logic [BURST_W-1:0] burst,
                                          input logic [PRIO_W-1:0] prio,
                                          input logic closes);
        item_t rec;
        rec.process_id = id;
        rec.arrival_time = arr;
        rec.burst_time = burst;
        rec.priority_value = prio;
        rec.last_process = closes;
        return rec;
    endfunction

    // narrow ranges most of the time so that arrivals overlap and priorities tie
    function automatic item_t random_record(input logic closes);
        item_t rec;
        rec.process_id = ID_W'($urandom_range(0, 255));
        rec.arrival_time = ($urandom_range(0, 3) == 0) ? ARR_W'($urandom_range(0, 65535))
                                                       : ARR_W'($urandom_range(0, 40));
        rec.burst_time = ($urandom_range(0, 3) == 0) ? BURST_W'($urandom_range(0, 65535))
                                                     : BURST_W'($urandom_range(0, 12));
        rec.priority_value = ($urandom_range(0, 2) == 0) ? PRIO_W'($urandom_range(0, 255))
                                                         : PRIO_W'($urandom_range(0, 3));
        rec.last_process = closes;
        return rec;
    endfunction

    // returns at the edge where the record transfers, or after a random gap that follows it when not eager
    task automatic send_record(input item_t rec, input bit eager);
        item <= rec;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        records_sent++;
        if (!eager && $urandom_range(0, 1) == 1)
        begin
            item_valid <= 1'b0;
            repeat (gap_length()) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int unsigned hold_served;
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned calm_left;
        hold_served = 0;
        hold_left = 0;
        stall_left = 0;
        calm_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                if (calm_left != 0)
                    calm_left--;
                else if ($urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(30, 120);
                else if ($urandom_range(0, 2) == 0)
                    stall_left = gap_length();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int unsigned stored;
        int unsigned batch;
        int unsigned size;
        int unsigned roll;
        bit          eager;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // lone record far in the future, every field at its top value
        send_record(make_record(8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1), 1'b0);

        // a priority and arrival tie broken by slot, a zero burst, idle jump at the end
        send_record(make_record(8'd0, 16'd10, 16'd0, 8'd5, 1'b0), 1'b1);
        send_record(make_record(8'd1, 16'd5, 16'd3, 8'd5, 1'b0), 1'b1);
        send_record(make_record(8'd2, 16'd5, 16'd4, 8'd5, 1'b0), 1'b0);
        send_record(make_record(8'd3, 16'd0, 16'd2, 8'd9, 1'b0), 1'b0);
        send_record(make_record(8'd4, 16'd100, 16'd1, 8'd0, 1'b1), 1'b0);
        wait_drained();

        // full table of longest bursts; two extra records are dropped, the second closes
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < MAX_PROCS_DEF + 2; k++)
            send_record(make_record(ID_W'(240 + k), '0, 16'hFFFF, PRIO_W'(k % 3),
                                    k == MAX_PROCS_DEF + 1), 1'b0);
        wait_drained();

        stored = 0;
        batch = 0;
        while (stored < RANDOM_RECORDS)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 7)
                size = $urandom_range(1, 6);
            else if (roll < 9)
                size = $urandom_range(7, MAX_PROCS_DEF);
            else
                size = MAX_PROCS_DEF + $urandom_range(1, 3);
            eager = ($urandom_range(0, 3) == 0);
            // output held off while the next batch keeps offering records
            if (batch == 1 || batch == 6)
                hold_requests <= hold_requests + 1;
            for (int k = 0; k < size; k++)
            begin
                send_record(random_record(k == size - 1), eager);
                if (k < MAX_PROCS_DEF)
                    stored++;
            end
            if (batch != 1 && batch != 6 && $urandom_range(0, 4) == 0)
                wait_drained();
            batch++;
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d batches from %0d offered records, %0d process reports checked",
                 batches_seen, records_sent, reports_seen);
        $display("incl. full table drops, clock jumps, priority ties and long output stalls");
        if (fail_count == 0 && pending_reports == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
